/* src/lfxr_pkg.sv */
// lfxr_pkg: shared types and codes for the length framed xor receiver
// no dependencies; used by the interfaces, the parser and the top level
`default_nettype none

package lfxr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdxW   = 9;
  localparam int unsigned VerW   = 3;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned CfgIdxW = 8;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [VerW-1:0]    verdict_t;
  typedef logic [PhaseW-1:0]  phase_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam phase_t PH_TYPE = 2'd0;
  localparam phase_t PH_LEN  = 2'd1;
  localparam phase_t PH_DATA = 2'd2;
  localparam phase_t PH_CSUM = 2'd3;

  localparam verdict_t V_NONE    = 3'd0;
  localparam verdict_t V_FORWARD = 3'd1;
  localparam verdict_t V_RESEND  = 3'd2;
  localparam verdict_t V_PEERACK = 3'd3;
  localparam verdict_t V_OVERRUN = 3'd4;

  localparam cfg_idx_t REG_ACK_TYPE  = 8'd0;
  localparam cfg_idx_t REG_NACK_TYPE = 8'd1;

  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_OVERRUN = 1'b1;

  typedef struct packed {
    phase_t phase;
    idx_t   count;
    byte_t  ftype;
    byte_t  flen;
    byte_t  xsum;
  } parse_st_t;

  typedef struct packed {
    byte_t    data_byte;
    idx_t     byte_index;
    logic     frame_end;
    verdict_t verdict;
  } result_t;

endpackage

`default_nettype wire

/* src/lfxr_if.sv */
// lfxr_in_if, lfxr_out_if, lfxr_cfg_if: valid/ready channels of the receiver
// depends on lfxr_pkg
`default_nettype none

interface lfxr_in_if;
  import lfxr_pkg::*;
  logic  valid;
  logic  ready;
  logic  mode;
  byte_t rx_byte;
  modport source (output valid, mode, rx_byte, input ready);
  modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface lfxr_out_if;
  import lfxr_pkg::*;
  logic     valid;
  logic     ready;
  byte_t    data_byte;
  idx_t     byte_index;
  logic     frame_end;
  verdict_t verdict;
  modport source (output valid, data_byte, byte_index, frame_end, verdict, input ready);
  modport sink   (input valid, data_byte, byte_index, frame_end, verdict, output ready);
endinterface

interface lfxr_cfg_if;
  import lfxr_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  byte_t    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/length_framed_xor_receiver.sv */
// length_framed_xor_receiver: type/length/payload/checksum frame parser
// depends on lfxr_pkg, lfxr_if and lfxr_parse
//
// in_ch carries received words (mode 0, rx_byte) or overrun events (mode 1).
// out_ch returns exactly one result word per input word, in order: the echoed
// byte, its position in the frame, a frame end flag and a verdict (forward,
// resend, peer ack or overrun) on the checksum byte.
// cfg_ch writes the ack type code (index 0) and nack type code (index 1);
// other indexes are dropped. cfg_ch is always ready; write only when idle.
// A word accepted at a clock edge has its result in the output register after
// that edge. Throughput is one word per cycle while out_ch does not stall, set by
// the parse state register which is updated in the same cycle as the result.
// in_ch.ready is high whenever the output register is empty or being drained,
// so a stall on out_ch holds the result and stops input only while it lasts.
// Synchronous active low reset returns the parser to awaiting a type byte,
// clears the count, type, length and checksum, empties the output register
// and sets the type codes to 0 (ack) and 1 (nack).
`default_nettype none

module length_framed_xor_receiver (
  input wire logic     clk,
  input wire logic     rst_n,
  lfxr_in_if.sink      in_ch,
  lfxr_out_if.source   out_ch,
  lfxr_cfg_if.sink     cfg_ch
);
  import lfxr_pkg::*;

  parse_st_t st_r;
  parse_st_t st_nxt;
  result_t   res;
  result_t   res_r;
  logic      out_valid_r;
  byte_t     ack_type_r;
  byte_t     nack_type_r;
  logic      in_acc;

  assign in_ch.ready  = ~out_valid_r | out_ch.ready;
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  lfxr_parse u_parse (
    .st        (st_r),
    .mode      (in_ch.mode),
    .rx_byte   (in_ch.rx_byte),
    .ack_type  (ack_type_r),
    .nack_type (nack_type_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
      ack_type_r  <= 8'd0;
      nack_type_r <= 8'd1;
    end else begin
      if (in_acc) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.index == REG_ACK_TYPE) begin
        ack_type_r <= cfg_ch.data;
      end
      if (cfg_ch.valid && cfg_ch.index == REG_NACK_TYPE) begin
        nack_type_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.data_byte  = res_r.data_byte;
  assign out_ch.byte_index = res_r.byte_index;
  assign out_ch.frame_end  = res_r.frame_end;
  assign out_ch.verdict    = res_r.verdict;

`ifndef SYNTHESIS
  a_overrun_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.mode == MODE_OVERRUN |=> out_valid_r && res_r.verdict == V_OVERRUN
      && !res_r.frame_end && $stable(st_r))
    else $error("overrun word did not give an overrun result or changed parse state");

  a_end_has_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.frame_end |-> res_r.verdict == V_FORWARD
      || res_r.verdict == V_RESEND || res_r.verdict == V_PEERACK)
    else $error("frame end without a frame verdict");

  a_type_phase_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_TYPE |-> st_r.count == '0 && st_r.xsum == '0)
    else $error("parser awaiting type with stale count or checksum");

  a_data_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_DATA |-> st_r.count < idx_t'(st_r.flen) + idx_t'(2)
      && st_r.count >= idx_t'(2))
    else $error("payload count outside frame length");
`endif

endmodule

`default_nettype wire

/* src/lfxr_parse.sv */
// lfxr_parse: next parse state and result word for one received word
// depends on lfxr_pkg; purely combinational
`default_nettype none

module lfxr_parse (
  input  lfxr_pkg::parse_st_t st,
  input  logic                mode,
  input  lfxr_pkg::byte_t     rx_byte,
  input  lfxr_pkg::byte_t     ack_type,
  input  lfxr_pkg::byte_t     nack_type,
  output lfxr_pkg::parse_st_t st_nxt,
  output lfxr_pkg::result_t   res
);
  import lfxr_pkg::*;

  idx_t count_inc;
  idx_t data_end;

  assign count_inc = st.count + idx_t'(1);
  assign data_end  = idx_t'(st.flen) + idx_t'(2);

  always_comb begin
    st_nxt         = st;
    res.data_byte  = rx_byte;
    res.byte_index = st.count;
    res.frame_end  = 1'b0;
    res.verdict    = V_NONE;
    if (mode == MODE_OVERRUN) begin
      res.data_byte  = '0;
      res.byte_index = '0;
      res.verdict    = V_OVERRUN;
    end else begin
      case (st.phase)
        PH_TYPE: begin
          res.byte_index = '0;
          st_nxt.ftype   = rx_byte;
          st_nxt.xsum    = '0;
          st_nxt.count   = idx_t'(1);
          st_nxt.phase   = PH_LEN;
        end
        PH_LEN: begin
          res.byte_index = idx_t'(1);
          st_nxt.flen    = rx_byte;
          st_nxt.count   = idx_t'(2);
          st_nxt.phase   = (rx_byte == '0) ? PH_CSUM : PH_DATA;
        end
        PH_DATA: begin
          st_nxt.xsum  = st.xsum ^ rx_byte;
          st_nxt.count = count_inc;
          if (count_inc == data_end) begin
            st_nxt.phase = PH_CSUM;
          end
        end
        default: begin
          res.frame_end = 1'b1;
          if (st.xsum != rx_byte || st.ftype == nack_type) begin
            res.verdict = V_RESEND;
          end else if (st.ftype != ack_type) begin
            res.verdict = V_FORWARD;
          end else begin
            res.verdict = V_PEERACK;
          end
          st_nxt.phase = PH_TYPE;
          st_nxt.count = '0;
          st_nxt.xsum  = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
